// ===== src/vpag_pkg.sv =====
// Types, constants and the broadcast mode table shared by the pixel aspect guess block.
package vpag_pkg;

  localparam int CSIZE_W = 12;
  localparam int SSIZE_W = 14;
  localparam int ASP_W   = 16;
  localparam int NUM_W   = 17;
  localparam int DEN_W   = 16;
  localparam int PROD_W  = 30;
  localparam int NFAC_W  = 7;
  localparam int DFAC_W  = 5;
  localparam int KCON_W  = 13;

  localparam logic [KCON_W-1:0] NUM_625 = 13'd128;
  localparam logic [KCON_W-1:0] DEN_625 = 13'd117;
  localparam logic [KCON_W-1:0] NUM_525 = 13'd4320;
  localparam logic [KCON_W-1:0] DEN_525 = 13'd4739;

  localparam logic [ASP_W-1:0] M1_DEN_NARROW_525 = 16'd11;
  localparam logic [ASP_W-1:0] M1_DEN_NARROW_625 = 16'd54;
  localparam logic [ASP_W-1:0] M1_DEN_WIDE_525   = 16'd27;
  localparam logic [ASP_W-1:0] M1_DEN_WIDE_625   = 16'd45;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_625  = 2'd1,
    MODE_525  = 2'd2
  } mode_code_t;

  typedef enum logic [1:0] {
    WF_ONE = 2'd0,
    WF_4_3 = 2'd1,
    WF_3_2 = 2'd2
  } wfac_t;

  typedef struct packed {
    logic       hit;
    logic       h576;
    logic [1:0] pw_sh;
    logic [1:0] ph_sh;
    wfac_t      wfac;
  } mode_info_t;

  typedef struct packed {
    logic              reject;
    logic              h576;
    logic [1:0]        pw_sh;
    logic [1:0]        ph_sh;
    wfac_t             wfac;
    logic              mpeg2;
    logic              wide1;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic [ASP_W-1:0]  an;
    logic [ASP_W-1:0]  ad;
  } work_t;

  // Shift counts give the doubling that brings height to 480 or more and width above 352.
  function automatic mode_info_t match_mode(input logic [CSIZE_W-1:0] cw,
                                            input logic [CSIZE_W-1:0] ch);
    mode_info_t m;
    m = '{hit: 1'b0, h576: 1'b0, pw_sh: 2'd0, ph_sh: 2'd0, wfac: WF_ONE};
    unique case ({cw, ch})
      {12'd720, 12'd576}: m = '{1'b1, 1'b1, 2'd0, 2'd0, WF_ONE};
      {12'd704, 12'd576}: m = '{1'b1, 1'b1, 2'd0, 2'd0, WF_ONE};
      {12'd544, 12'd576}: m = '{1'b1, 1'b1, 2'd0, 2'd0, WF_4_3};
      {12'd528, 12'd576}: m = '{1'b1, 1'b1, 2'd0, 2'd0, WF_4_3};
      {12'd480, 12'd576}: m = '{1'b1, 1'b1, 2'd0, 2'd0, WF_3_2};
      {12'd352, 12'd576}: m = '{1'b1, 1'b1, 2'd1, 2'd0, WF_ONE};
      {12'd352, 12'd288}: m = '{1'b1, 1'b1, 2'd1, 2'd1, WF_ONE};
      {12'd176, 12'd144}: m = '{1'b1, 1'b1, 2'd2, 2'd2, WF_ONE};
      {12'd720, 12'd486}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_ONE};
      {12'd704, 12'd486}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_ONE};
      {12'd720, 12'd480}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_ONE};
      {12'd704, 12'd480}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_ONE};
      {12'd544, 12'd480}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_4_3};
      {12'd528, 12'd480}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_4_3};
      {12'd480, 12'd480}: m = '{1'b1, 1'b0, 2'd0, 2'd0, WF_3_2};
      {12'd352, 12'd480}: m = '{1'b1, 1'b0, 2'd1, 2'd0, WF_ONE};
      {12'd352, 12'd240}: m = '{1'b1, 1'b0, 2'd1, 2'd1, WF_ONE};
      default:            m = '{1'b0, 1'b0, 2'd0, 2'd0, WF_ONE};
    endcase
    return m;
  endfunction

endpackage

// ===== src/video_pixel_aspect_guess.sv =====
// Top level of the pixel aspect guess block: front stage, queue and back stage.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_tvalid/in_tready  | in_tdata 88 bits, in_tuser 1 bit
//  out_    | output    | out_tvalid/out_tready| out_tdata 40 bits, out_tuser 2 bits
//
// One item is accepted every cycle while the output is not stalled.
// Each item passes through the front register, one slot of the two-entry queue and the result register.
// Reset is synchronous and active low; it empties all stages, and no clearing pass follows.
// A stall at the output fills the result register, then the queue and then the front register
// before in_tready drops, so four items can be in flight.
module video_pixel_aspect_guess (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // coded_width[11:0], coded_height[23:12], shown_width[37:24], shown_height[51:38],
  // aspect_num_in[67:52], aspect_den_in[83:68], zero fill[87:84]
  input  logic [87:0] in_tdata,
  // is_mpeg2[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // aspect_num_out[16:0], aspect_den_out[32:17], zero fill[39:33]
  output logic [39:0] out_tdata,
  // mode_code[1:0]
  output logic [1:0]  out_tuser
);

  logic                       push_valid;
  logic                       push_ready;
  vpag_pkg::work_t            push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  vpag_pkg::work_t            pop_data;
  logic [vpag_pkg::NUM_W-1:0] num_out;
  logic [vpag_pkg::DEN_W-1:0] den_out;
  vpag_pkg::mode_code_t       code_out;

  vpag_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .coded_width   (in_tdata[11:0]),
    .coded_height  (in_tdata[23:12]),
    .shown_width   (in_tdata[37:24]),
    .shown_height  (in_tdata[51:38]),
    .aspect_num_in (in_tdata[67:52]),
    .aspect_den_in (in_tdata[83:68]),
    .is_mpeg2      (in_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  vpag_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  vpag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .num_out   (num_out),
    .den_out   (den_out),
    .code_out  (code_out)
  );

  assign out_tdata = {7'd0, den_out, num_out};
  assign out_tuser = code_out;

endmodule

// ===== src/vpag_front.sv =====
// Front stage: accepts headers, matches the mode, checks rejection and forms the 4:3 comparison products.
module vpag_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [vpag_pkg::CSIZE_W-1:0] coded_width,
  input  logic [vpag_pkg::CSIZE_W-1:0] coded_height,
  input  logic [vpag_pkg::SSIZE_W-1:0] shown_width,
  input  logic [vpag_pkg::SSIZE_W-1:0] shown_height,
  input  logic [vpag_pkg::ASP_W-1:0]   aspect_num_in,
  input  logic [vpag_pkg::ASP_W-1:0]   aspect_den_in,
  input  logic                         is_mpeg2,
  output logic                         push_valid,
  input  logic                         push_ready,
  output vpag_pkg::work_t              push_data
);

  logic                        valid_r;
  vpag_pkg::work_t             data_r;
  vpag_pkg::work_t             data_nxt;
  vpag_pkg::mode_info_t        mi;
  logic                        size_ok;
  logic                        square;
  logic                        wide1;
  logic [vpag_pkg::ASP_W-1:0]  den_exp;
  logic                        mp1_bad;
  logic [vpag_pkg::SSIZE_W-1:0] cw3;
  logic [vpag_pkg::SSIZE_W-1:0] ch4;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_data  = data_r;

  always_comb begin
    mi      = vpag_pkg::match_mode(coded_width, coded_height);
    size_ok = ({2'b00, coded_width} == shown_width) && ({2'b00, coded_height} == shown_height);
    square  = (aspect_num_in == 16'd1) && (aspect_den_in == 16'd1);
    wide1   = (aspect_den_in == vpag_pkg::M1_DEN_WIDE_525) ||
              (aspect_den_in == vpag_pkg::M1_DEN_WIDE_625);
    if (wide1) begin
      den_exp = mi.h576 ? vpag_pkg::M1_DEN_WIDE_625 : vpag_pkg::M1_DEN_WIDE_525;
    end else begin
      den_exp = mi.h576 ? vpag_pkg::M1_DEN_NARROW_625 : vpag_pkg::M1_DEN_NARROW_525;
    end
    mp1_bad = !is_mpeg2 && ((mi.wfac != vpag_pkg::WF_ONE) || (aspect_den_in != den_exp));
    cw3     = vpag_pkg::SSIZE_W'({2'b00, coded_width} * 14'd3);
    ch4     = {coded_height, 2'b00};

    data_nxt.reject = !mi.hit || square || !size_ok || mp1_bad;
    data_nxt.h576   = mi.h576;
    data_nxt.pw_sh  = mi.pw_sh;
    data_nxt.ph_sh  = mi.ph_sh;
    data_nxt.wfac   = mi.wfac;
    data_nxt.mpeg2  = is_mpeg2;
    data_nxt.wide1  = wide1;
    data_nxt.lhs    = vpag_pkg::PROD_W'(cw3) * vpag_pkg::PROD_W'(aspect_num_in);
    data_nxt.rhs    = vpag_pkg::PROD_W'(ch4) * vpag_pkg::PROD_W'(aspect_den_in);
    data_nxt.an     = aspect_num_in;
    data_nxt.ad     = aspect_den_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== src/vpag_queue.sv =====
// Two-entry queue that decouples the front stage from the back stage.
module vpag_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  vpag_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output vpag_pkg::work_t pop_data
);

  vpag_pkg::work_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("Queue count out of range.");

  a_ptrs_track: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == 2'd0) || (count_r == 2'd2)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("Queue pointers disagree with the count.");

endmodule

// ===== src/vpag_back.sv =====
// Back stage: resolves the wide test, builds the scale factors and registers the result item.
module vpag_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  vpag_pkg::work_t             pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vpag_pkg::NUM_W-1:0]  num_out,
  output logic [vpag_pkg::DEN_W-1:0]  den_out,
  output vpag_pkg::mode_code_t        code_out
);

  logic                         valid_r;
  logic [vpag_pkg::NUM_W-1:0]   num_r;
  logic [vpag_pkg::NUM_W-1:0]   num_nxt;
  logic [vpag_pkg::DEN_W-1:0]   den_r;
  logic [vpag_pkg::DEN_W-1:0]   den_nxt;
  vpag_pkg::mode_code_t         code_r;
  vpag_pkg::mode_code_t         code_nxt;
  logic                         wide;
  logic [vpag_pkg::NFAC_W-1:0]  nbase;
  logic [vpag_pkg::NFAC_W-1:0]  nfac;
  logic [vpag_pkg::DFAC_W-1:0]  dbase;
  logic [vpag_pkg::DFAC_W-1:0]  dfac;
  logic [vpag_pkg::KCON_W-1:0]  nk;
  logic [vpag_pkg::KCON_W-1:0]  dk;
  logic [19:0]                  num_full;
  logic [17:0]                  den_full;

  assign pop_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign num_out   = num_r;
  assign den_out   = den_r;
  assign code_out  = code_r;

  always_comb begin
    wide = pop_data.mpeg2 ? (pop_data.lhs > pop_data.rhs) : pop_data.wide1;
    case (pop_data.wfac)
      vpag_pkg::WF_4_3: begin
        nbase = 7'd4;
        dbase = 5'd3;
      end
      vpag_pkg::WF_3_2: begin
        nbase = 7'd3;
        dbase = 5'd2;
      end
      default: begin
        nbase = 7'd1;
        dbase = 5'd1;
      end
    endcase
    nfac = nbase << pop_data.pw_sh;
    dfac = dbase << pop_data.ph_sh;
    if (wide) begin
      nfac = nfac << 2;
      dfac = vpag_pkg::DFAC_W'(dfac * 5'd3);
    end
    nk       = pop_data.h576 ? vpag_pkg::NUM_625 : vpag_pkg::NUM_525;
    dk       = pop_data.h576 ? vpag_pkg::DEN_625 : vpag_pkg::DEN_525;
    num_full = 20'(nfac) * 20'(nk);
    den_full = 18'(dfac) * 18'(dk);
    if (pop_data.reject) begin
      num_nxt  = {1'b0, pop_data.an};
      den_nxt  = pop_data.ad;
      code_nxt = vpag_pkg::MODE_NONE;
    end else begin
      num_nxt  = num_full[vpag_pkg::NUM_W-1:0];
      den_nxt  = den_full[vpag_pkg::DEN_W-1:0];
      code_nxt = pop_data.h576 ? vpag_pkg::MODE_625 : vpag_pkg::MODE_525;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      code_r <= code_nxt;
    end
  end

  a_625_num_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (code_r == vpag_pkg::MODE_625)) |-> (num_r[6:0] == 7'd0))
    else $error("A 625-line numerator is not a multiple of 128.");

  a_pass_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (code_r == vpag_pkg::MODE_NONE)) |-> !num_r[vpag_pkg::NUM_W-1])
    else $error("A passed-through numerator exceeds the input width.");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(num_r) && $stable(den_r)))
    else $error("The result register changed while stalled.");

endmodule

// ===== bench/tb_video_pixel_aspect_guess.sv =====
// Self-checking testbench for the pixel aspect guess block on its streaming ports.
`timescale 1ns / 1ps

module tb_video_pixel_aspect_guess;

  typedef struct packed {
    logic [11:0] cw;
    logic [11:0] ch;
    logic [13:0] sw;
    logic [13:0] sh;
    logic [15:0] an;
    logic [15:0] ad;
    logic        mpeg2;
  } header_t;

  typedef struct packed {
    logic [16:0]          num;
    logic [15:0]          den;
    vpag_pkg::mode_code_t mode;
  } result_t;

  typedef struct packed {
    header_t hd;
    logic    typed;
    result_t want;
  } stim_row_t;

  localparam result_t NO_RESULT = '{17'd0, 16'd0, vpag_pkg::MODE_NONE};

  localparam logic [15:0] DEN_NARROW_525 = 16'd11;
  localparam logic [15:0] DEN_NARROW_625 = 16'd54;
  localparam logic [15:0] DEN_WIDE_525   = 16'd27;
  localparam logic [15:0] DEN_WIDE_625   = 16'd45;

  int unsigned bcast_w [0:16] = '{720, 704, 544, 528, 480, 352, 352, 176,
                                  720, 704, 720, 704, 544, 528, 480, 352, 352};
  int unsigned bcast_h [0:16] = '{576, 576, 576, 576, 576, 576, 288, 144,
                                  486, 486, 480, 480, 480, 480, 480, 480, 240};

  stim_row_t directed_rows [0:24] = '{
    '{'{12'd0, 12'd0, 14'd0, 14'd0, 16'd0, 16'd0, 1'b0}, 1'b1,
      '{17'd0, 16'd0, vpag_pkg::MODE_NONE}},
    '{'{12'd4095, 12'd4095, 14'd16383, 14'd16383, 16'd65535, 16'd65535, 1'b1}, 1'b1,
      '{17'd65535, 16'd65535, vpag_pkg::MODE_NONE}},
    '{'{12'd720, 12'd576, 14'd720, 14'd576, 16'd1, 16'd1, 1'b1}, 1'b1,
      '{17'd1, 16'd1, vpag_pkg::MODE_NONE}},
    '{'{12'd352, 12'd240, 14'd352, 14'd240, 16'd1, 16'd1, 1'b0}, 1'b1,
      '{17'd1, 16'd1, vpag_pkg::MODE_NONE}},
    '{'{12'd720, 12'd576, 14'd720, 14'd480, 16'd16, 16'd11, 1'b1}, 1'b1,
      '{17'd16, 16'd11, vpag_pkg::MODE_NONE}},
    '{'{12'd720, 12'd576, 14'd4816, 14'd576, 16'd16, 16'd11, 1'b1}, 1'b1,
      '{17'd16, 16'd11, vpag_pkg::MODE_NONE}},
    '{'{12'd544, 12'd576, 14'd544, 14'd576, 16'd4, 16'd54, 1'b0}, 1'b1,
      '{17'd4, 16'd54, vpag_pkg::MODE_NONE}},
    '{'{12'd720, 12'd576, 14'd720, 14'd576, 16'd4, 16'd11, 1'b0}, 1'b1,
      '{17'd4, 16'd11, vpag_pkg::MODE_NONE}},
    '{'{12'd720, 12'd480, 14'd720, 14'd480, 16'd4, 16'd45, 1'b0}, 1'b1,
      '{17'd4, 16'd45, vpag_pkg::MODE_NONE}},
    '{'{12'd720, 12'd576, 14'd720, 14'd576, 16'd4, 16'd54, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd720, 12'd576, 14'd720, 14'd576, 16'd4, 16'd45, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd720, 12'd480, 14'd720, 14'd480, 16'd4, 16'd11, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd704, 12'd486, 14'd704, 14'd486, 16'd4, 16'd27, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd352, 12'd288, 14'd352, 14'd288, 16'd4, 16'd54, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd176, 12'd144, 14'd176, 14'd144, 16'd4, 16'd45, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd352, 12'd240, 14'd352, 14'd240, 16'd4, 16'd11, 1'b0}, 1'b0, NO_RESULT},
    '{'{12'd720, 12'd576, 14'd720, 14'd576, 16'd16, 16'd15, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd720, 12'd576, 14'd720, 14'd576, 16'd16, 16'd14, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd544, 12'd480, 14'd544, 14'd480, 16'd65535, 16'd1, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd528, 12'd576, 14'd528, 14'd576, 16'd1, 16'd2, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd480, 12'd480, 14'd480, 14'd480, 16'd2, 16'd1, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd480, 12'd576, 14'd480, 14'd576, 16'd0, 16'd0, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd352, 12'd576, 14'd352, 14'd576, 16'd10, 16'd11, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd176, 12'd144, 14'd176, 14'd144, 16'd65535, 16'd65535, 1'b1}, 1'b0, NO_RESULT},
    '{'{12'd720, 12'd486, 14'd720, 14'd486, 16'd8, 16'd9, 1'b1}, 1'b0, NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  logic        row_typed = 1'b0;
  result_t     row_want = NO_RESULT;
  bit          calm = 1'b0;
  int          fail_count = 0;
  result_t     expected_aspects [$];

  video_pixel_aspect_guess i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t predict_aspect(input header_t hd);
    result_t     r;
    bit          hit;
    bit          wide;
    int          k;
    int unsigned pw;
    int unsigned ph;
    int unsigned w;
    int unsigned h;
    logic [15:0] table_den;
    longint unsigned lhs;
    longint unsigned rhs;
    r.num = {1'b0, hd.an};
    r.den = hd.ad;
    r.mode = vpag_pkg::MODE_NONE;
    hit = 1'b0;
    for (k = 0; k < 17; k++) begin
      if (32'(hd.cw) == bcast_w[k] && 32'(hd.ch) == bcast_h[k]) begin
        hit = 1'b1;
      end
    end
    if (!hit || (hd.an == 16'd1 && hd.ad == 16'd1) ||
        hd.sw != {2'b00, hd.cw} || hd.sh != {2'b00, hd.ch}) begin
      return r;
    end
    ph = 1;
    while (32'(hd.ch) * ph < 480) begin
      ph = ph * 2;
    end
    h = 32'(hd.ch) * ph;
    pw = 1;
    while (32'(hd.cw) * pw <= 352) begin
      pw = pw * 2;
    end
    w = 32'(hd.cw) * pw;
    if (!hd.mpeg2) begin
      wide = (hd.ad == DEN_WIDE_525 || hd.ad == DEN_WIDE_625);
      if (wide) begin
        table_den = (h == 576) ? DEN_WIDE_625 : DEN_WIDE_525;
      end else begin
        table_den = (h == 576) ? DEN_NARROW_625 : DEN_NARROW_525;
      end
      if (w < 704 || hd.ad != table_den) begin
        return r;
      end
    end else begin
      lhs = 64'(hd.cw);
      lhs = lhs * 64'd3 * 64'(hd.an);
      rhs = 64'(hd.ch);
      rhs = rhs * 64'd4 * 64'(hd.ad);
      wide = lhs > rhs;
      if (w == 528 || w == 544) begin
        pw = pw * 4;
        ph = ph * 3;
      end else if (w == 480) begin
        pw = pw * 3;
        ph = ph * 2;
      end
    end
    if (wide) begin
      pw = pw * 4;
      ph = ph * 3;
    end
    if (h == 576) begin
      pw = pw * 128;
      ph = ph * 117;
      r.mode = vpag_pkg::MODE_625;
    end else begin
      pw = pw * 4320;
      ph = ph * 4739;
      r.mode = vpag_pkg::MODE_525;
    end
    r.num = pw[16:0];
    r.den = ph[15:0];
    return r;
  endfunction

  task automatic send_header(input header_t hd, input logic typed, input result_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, hd.ad, hd.an, hd.sh, hd.sw, hd.ch, hd.cw};
    in_tuser  <= hd.mpeg2;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Expectations are queued and results checked in one process, so the order is fixed.
  always @(posedge clk) begin
    header_t hd;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        hd.cw    = in_tdata[11:0];
        hd.ch    = in_tdata[23:12];
        hd.sw    = in_tdata[37:24];
        hd.sh    = in_tdata[51:38];
        hd.an    = in_tdata[67:52];
        hd.ad    = in_tdata[83:68];
        hd.mpeg2 = in_tuser;
        expected_aspects.push_back(row_typed ? row_want : predict_aspect(hd));
      end
      if (out_tvalid && out_tready) begin
        got.num  = out_tdata[16:0];
        got.den  = out_tdata[32:17];
        got.mode = vpag_pkg::mode_code_t'(out_tuser);
        if (expected_aspects.size() == 0) begin
          $error("unexpected result item: num %0d den %0d mode %0d",
                 got.num, got.den, got.mode);
          fail_count++;
        end else begin
          want = expected_aspects.pop_front();
          if (got.num !== want.num) begin
            $error("aspect_num_out: expected %0d, got %0d", want.num, got.num);
            fail_count++;
          end
          if (got.den !== want.den) begin
            $error("aspect_den_out: expected %0d, got %0d", want.den, got.den);
            fail_count++;
          end
          if (got.mode !== want.mode) begin
            $error("mode_code: expected %0d, got %0d", want.mode, got.mode);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    header_t hd;
    int      n;
    int      kind;
    int      k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < $size(directed_rows); n++) begin
      send_header(directed_rows[n].hd, directed_rows[n].typed, directed_rows[n].want);
    end

    for (n = 0; n < 450; n++) begin
      calm = ((n / 60) % 4 == 3);
      kind = $urandom_range(0, 99);
      k = $urandom_range(0, 16);
      hd.cw    = 12'(bcast_w[k]);
      hd.ch    = 12'(bcast_h[k]);
      hd.sw    = 14'(bcast_w[k]);
      hd.sh    = 14'(bcast_h[k]);
      hd.mpeg2 = 1'($urandom_range(0, 1));
      if (kind < 35) begin
        hd.an = 16'($urandom);
        hd.ad = 16'($urandom);
      end else begin
        hd.an = 16'($urandom_range(0, 24));
        hd.ad = 16'($urandom_range(0, 24));
      end
      if (!hd.mpeg2 && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0:       hd.ad = DEN_NARROW_525;
          1:       hd.ad = DEN_NARROW_625;
          2:       hd.ad = DEN_WIDE_525;
          default: hd.ad = DEN_WIDE_625;
        endcase
      end
      if (kind >= 70 && kind < 78) begin
        hd.an = 16'd1;
        hd.ad = 16'd1;
      end else if (kind >= 78 && kind < 86) begin
        case ($urandom_range(0, 3))
          0:       hd.sw = hd.sw ^ (14'd1 << $urandom_range(0, 13));
          1:       hd.sh = hd.sh ^ (14'd1 << $urandom_range(0, 13));
          2:       begin
            hd.cw = hd.cw + 12'd1;
            hd.sw = {2'b00, hd.cw};
          end
          default: begin
            hd.ch = hd.ch - 12'd1;
            hd.sh = {2'b00, hd.ch};
          end
        endcase
      end else if (kind >= 86) begin
        hd.cw    = 12'($urandom);
        hd.ch    = 12'($urandom);
        hd.sw    = 14'($urandom);
        hd.sh    = 14'($urandom);
        hd.an    = 16'($urandom);
        hd.ad    = 16'($urandom);
        hd.mpeg2 = 1'($urandom);
      end
      send_header(hd, 1'b0, NO_RESULT);
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (expected_aspects.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
src/vpag_pkg.sv
src/vpag_front.sv
src/vpag_queue.sv
src/vpag_back.sv
src/video_pixel_aspect_guess.sv
bench/tb_video_pixel_aspect_guess.sv
